[rtl/core/lrt_pkg.sv]
package lrt_pkg;

	localparam int FID_W   = 6;
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 7;
	localparam int CAP_W   = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic [FID_W-1:0] fid_t;

	localparam cmd_t CMD_VICTIM = 2'd0;
	localparam cmd_t CMD_PIN    = 2'd1;
	localparam cmd_t CMD_UNPIN  = 2'd2;
	localparam cmd_t CMD_QUERY  = 2'd3;

	typedef struct packed {
		logic unpin_add;
		logic pin_del;
		logic evict;
	} list_op_t;

endpackage

[rtl/core/lru_replacement_tracker_core.sv]
// LRU replacement tracker.
// Input stream s_axis: one beat per command. tdata[1:0] is cmd (0 victim,
// 1 pin, 2 unpin, 3 query), tdata[7:2] is the frame number.
// Output stream m_axis: exactly one beat per input beat, in order.
// tdata[0] found, [6:1] victim_frame (0 unless found), [13:7] count after
// the command, [15:14] zero.
// Capacity register: write cfg_wdata with cfg_we high while no command is
// in flight; it bounds the list together with FRAMES.
// Flow: an accepted beat waits in the input register, is resolved once the
// output register is free, and its result is registered there.
// Throughput: one command per cycle while m_axis_tready is high; each
// is resolved by the slot row (parallel compare, shift and evict select)
// and the per-frame listed bits, so the next command sees the new list.
// Stall: when m_axis_tready is low the result register holds and the input
// register behind it fills; s_axis_tready then drops until the output beat
// is taken.
// Reset: the list is empty, capacity is 64, nothing is in flight; no
// clearing pass is needed.
module lru_replacement_tracker_core
	import lrt_pkg::*;
#(
	parameter int FRAMES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CAP_W-1:0]   cfg_wdata,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // cmd, frame
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [15:0]        m_axis_tdata    // found, victim_frame, count, pad
);

	localparam int IDS = (FRAMES < (1 << FID_W)) ? FRAMES : (1 << FID_W);
	localparam int IW  = $clog2(IDS);
	localparam int CW  = $clog2(IDS + 1);

	logic [CAP_W-1:0]   cap_q;
	logic               valid_s1;
	cmd_t               cmd_s1;
	fid_t               fid_s1;
	logic               m_valid_q;
	logic               found_q;
	fid_t               vframe_q;
	logic [COUNT_W-1:0] count_q;

	logic               advance;
	logic               fire;
	logic               in_range;
	logic               hit;
	list_op_t           op;
	logic [CW-1:0]      count;
	logic [CW-1:0]      count_next;
	fid_t               oldest_id;
	logic               mem_wr_en;
	logic               mem_wr_set;
	logic [IW-1:0]      mem_wr_idx;

	assign advance       = !m_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1 <= s_axis_tdata[CMD_W-1:0];
			fid_s1 <= s_axis_tdata[CMD_W +: FID_W];
		end
	end

	assign in_range = 32'(fid_s1) < 32'(FRAMES);

	always_comb begin
		op = '0;
		if (fire) begin
			case (cmd_s1)
				CMD_VICTIM: begin
					op.evict = (count != '0);
				end
				CMD_PIN: begin
					op.pin_del = in_range && hit;
				end
				CMD_UNPIN: begin
					op.unpin_add = in_range && !hit && (COUNT_W'(count) < cap_q);
				end
				default: begin
					op = '0;
				end
			endcase
		end
	end

	assign mem_wr_en  = op.evict || op.pin_del || op.unpin_add;
	assign mem_wr_set = op.unpin_add;
	assign mem_wr_idx = op.evict ? oldest_id[IW-1:0] : fid_s1[IW-1:0];

	lrt_member #(
		.IDS (IDS),
		.IW  (IW)
	) u_member (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mem_wr_en),
		.wr_set (mem_wr_set),
		.wr_idx (mem_wr_idx),
		.rd_idx (fid_s1[IW-1:0]),
		.rd_hit (hit)
	);

	lrt_list #(
		.SLOTS (IDS),
		.CW    (CW)
	) u_list (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.fid        (fid_s1),
		.count      (count),
		.count_next (count_next),
		.oldest_id  (oldest_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			found_q  <= op.evict;
			vframe_q <= op.evict ? oldest_id : '0;
			count_q  <= COUNT_W'(count_next);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, count_q, vframe_q, found_q};

endmodule

[rtl/core/lrt_member.sv]
module lrt_member
	import lrt_pkg::*;
#(
	parameter int IDS = 64,
	parameter int IW  = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic          wr_set,
	input  logic [IW-1:0] wr_idx,
	input  logic [IW-1:0] rd_idx,
	output logic          rd_hit
);

	logic [IDS-1:0] listed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			listed_q <= '0;
		end else if (wr_en) begin
			listed_q[wr_idx] <= wr_set;
		end
	end

	assign rd_hit = listed_q[rd_idx];

endmodule

[rtl/core/lrt_list.sv]
module lrt_list
	import lrt_pkg::*;
#(
	parameter int SLOTS = 64,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  list_op_t      op,
	input  fid_t          fid,
	output logic [CW-1:0] count,
	output logic [CW-1:0] count_next,
	output fid_t          oldest_id
);

	fid_t              slot_q [SLOTS];
	fid_t              slot_d [SLOTS];
	logic [SLOTS-1:0]  occ_q;
	logic [SLOTS-1:0]  occ_d;
	logic [CW-1:0]     count_q;
	logic [SLOTS-1:0]  match;
	logic [SLOTS-1:0]  at_or_after;
	logic [SLOTS-1:0]  oldest;

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			match[k] = occ_q[k] && (slot_q[k] == fid);
		end
		at_or_after = ~(match - SLOTS'(1));
		oldest = occ_q & ~(occ_q >> 1);
		oldest_id = '0;
		for (int k = 0; k < SLOTS; k++) begin
			oldest_id = oldest_id | (slot_q[k] & {FID_W{oldest[k]}});
		end
	end

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			slot_d[k] = slot_q[k];
			occ_d[k]  = occ_q[k];
		end
		if (op.unpin_add) begin
			slot_d[0] = fid;
			occ_d[0]  = 1'b1;
			for (int k = 1; k < SLOTS; k++) begin
				slot_d[k] = slot_q[k-1];
				occ_d[k]  = occ_q[k-1];
			end
		end else if (op.pin_del) begin
			for (int k = 0; k < SLOTS - 1; k++) begin
				if (at_or_after[k]) begin
					slot_d[k] = slot_q[k+1];
					occ_d[k]  = occ_q[k+1];
				end
			end
			if (at_or_after[SLOTS-1]) begin
				occ_d[SLOTS-1] = 1'b0;
			end
		end else if (op.evict) begin
			occ_d = occ_q & ~oldest;
		end
	end

	always_comb begin
		count_next = count_q;
		if (op.unpin_add) begin
			count_next = count_q + CW'(1);
		end else if (op.pin_del || op.evict) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < SLOTS; k++) begin
			slot_q[k] <= slot_d[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
		end else begin
			occ_q   <= occ_d;
			count_q <= count_next;
		end
	end

	assign count = count_q;

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_q) == 32'(count_q))
		else $error("occupancy does not match count");

	a_op_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(op))
		else $error("more than one list operation");

	a_pin_match: assert property (@(posedge clk) disable iff (!arst_n)
		op.pin_del |-> $onehot(match))
		else $error("pin without exactly one listed match");

	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		op.evict |-> (count_q != '0))
		else $error("evict on empty list");

	a_add_room: assert property (@(posedge clk) disable iff (!arst_n)
		op.unpin_add |-> !occ_q[SLOTS-1])
		else $error("unpin into full slot row");

endmodule

[test/tb.sv]
module tb;
	import lrt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES = 64;

	typedef struct packed {
		logic [1:0]         pad;
		logic [COUNT_W-1:0] count;
		fid_t               victim_frame;
		logic               found;
	} lru_result_t;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CAP_W-1:0]   cfg_wdata = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = '0;     // cmd, frame
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [15:0]        m_axis_tdata;          // found, victim_frame, count, pad

	fid_t               lru_list[$];
	logic               listed[FRAMES];
	logic [CAP_W-1:0]   capacity_shadow;
	lru_result_t        pending_results[$];

	int unsigned        err_cnt = 0;
	int unsigned        burst_left = 0;
	bit                 no_gap = 1'b0;
	logic               hold_active = 1'b0;
	sink_mode_t         sink_mode = SINK_OPEN;
	int unsigned        sink_left = 0;
	logic               sink_ready;

	lru_replacement_tracker_core #(
		.FRAMES(FRAMES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#1_600_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic lru_result_t apply_cmd(cmd_t c, fid_t f);
		lru_result_t r;
		int unsigned limit;
		r = '0;
		limit = (capacity_shadow < FRAMES) ? capacity_shadow : FRAMES;
		case (c)
			CMD_VICTIM: begin
				if (lru_list.size() > 0) begin
					r.victim_frame = lru_list.pop_back();
					listed[r.victim_frame] = 1'b0;
					r.found = 1'b1;
				end
			end
			CMD_PIN: begin
				if (listed[f]) begin
					for (int i = 0; i < lru_list.size(); i++) begin
						if (lru_list[i] == f) begin
							lru_list.delete(i);
							break;
						end
					end
					listed[f] = 1'b0;
				end
			end
			CMD_UNPIN: begin
				if (!listed[f] && lru_list.size() < limit) begin
					lru_list.push_front(f);
					listed[f] = 1'b1;
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(lru_list.size());
		return r;
	endfunction

	function automatic void check_beat(lru_result_t got);
		lru_result_t want;
		if (pending_results.size() == 0) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("unexpected result beat: %h", got);
			return;
		end
		want = pending_results.pop_front();
		if (got.found !== want.found || got.victim_frame !== want.victim_frame ||
				got.count !== want.count || got.pad !== want.pad) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display({"result mismatch: exp found=%0d frame=%0d count=%0d pad=%0d,",
					" act found=%0d frame=%0d count=%0d pad=%0d"},
					want.found, want.victim_frame, want.count, want.pad,
					got.found, got.victim_frame, got.count, got.pad);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_beat(m_axis_tdata);
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = $urandom_range(8, 80);
		end
		sink_left--;
		case (sink_mode)
			SINK_OPEN:   sink_ready = 1'b1;
			SINK_COIN:   sink_ready = ($urandom_range(0, 1) == 1);
			SINK_MOSTLY: sink_ready = ($urandom_range(0, 9) != 0);
			default:     sink_ready = ($urandom_range(0, 3) == 0);
		endcase
		m_axis_tready <= !hold_active && sink_ready;
	end

	task automatic send_cmd(cmd_t c, fid_t f);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = no_gap ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {f, c};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_cmd(c, f));
	endtask

	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] value);
		wait_results_done();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_shadow = value;
	endtask

	task automatic send_random_cmd();
		cmd_t c;
		fid_t f;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			c = CMD_UNPIN;
		else if (pick < 65)
			c = CMD_PIN;
		else if (pick < 90)
			c = CMD_VICTIM;
		else
			c = CMD_QUERY;
		if (lru_list.size() > 0 && $urandom_range(0, 2) == 0)
			f = lru_list[$urandom_range(0, lru_list.size() - 1)];
		else if ($urandom_range(0, 1))
			f = fid_t'($urandom_range(0, 7));
		else
			f = fid_t'($urandom_range(0, FRAMES - 1));
		send_cmd(c, f);
	endtask

	task automatic test_basic_commands();
		no_gap = 1'b0;
		send_cmd(CMD_QUERY, 6'd0);
		send_cmd(CMD_VICTIM, 6'd63);
		send_cmd(CMD_PIN, 6'd5);
		send_cmd(CMD_UNPIN, 6'd0);
		send_cmd(CMD_UNPIN, 6'd63);
		send_cmd(CMD_UNPIN, 6'd21);
		send_cmd(CMD_UNPIN, 6'd42);
		send_cmd(CMD_UNPIN, 6'd63);
		send_cmd(CMD_QUERY, 6'd63);
		send_cmd(CMD_PIN, 6'd7);
		send_cmd(CMD_PIN, 6'd21);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_UNPIN, 6'd0);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_QUERY, 6'd0);
	endtask

	task automatic test_capacity_lowered();
		set_capacity(7'd0);
		send_cmd(CMD_UNPIN, 6'd9);
		set_capacity(7'd64);
		for (int i = 0; i < 6; i++)
			send_cmd(CMD_UNPIN, fid_t'(i * 10 + 3));
		set_capacity(7'd3);
		send_cmd(CMD_UNPIN, 6'd1);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_PIN, 6'd23);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_UNPIN, 6'd1);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_UNPIN, 6'd1);
		send_cmd(CMD_UNPIN, 6'd2);
	endtask

	task automatic test_full_list();
		fid_t ids[FRAMES];
		fid_t tmp;
		int unsigned j;
		for (int i = 0; i < FRAMES; i++)
			ids[i] = fid_t'(i);
		for (int i = FRAMES - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = ids[i];
			ids[i] = ids[j];
			ids[j] = tmp;
		end
		set_capacity(7'd127);
		no_gap = 1'b1;
		for (int i = 0; i < FRAMES; i++)
			send_cmd(CMD_UNPIN, ids[i]);
		send_cmd(CMD_UNPIN, ids[0]);
		send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_UNPIN, ids[0]);
		send_cmd(CMD_UNPIN, ids[1]);
		send_cmd(CMD_QUERY, 6'd0);
		set_capacity(7'd64);
		send_cmd(CMD_PIN, ids[10]);
		send_cmd(CMD_UNPIN, ids[10]);
		send_cmd(CMD_UNPIN, ids[20]);
		no_gap = 1'b0;
		while (lru_list.size() > 0)
			send_cmd(CMD_VICTIM, 6'd0);
		send_cmd(CMD_VICTIM, 6'd0);
	endtask

	task automatic test_backpressure();
		set_capacity(7'd16);
		no_gap = 1'b1;
		fork
			begin
				hold_active <= 1'b1;
				repeat (300) @(posedge clk);
				hold_active <= 1'b0;
			end
			repeat (40) send_random_cmd();
		join
		no_gap = 1'b0;
		wait_results_done();
	endtask

	task automatic test_random_mix();
		logic [CAP_W-1:0] caps[8];
		caps = '{7'd64, 7'd1, 7'd0, 7'd5, 7'd127, 7'd17, 7'd64, 7'd0};
		caps[7] = CAP_W'($urandom_range(0, 64));
		for (int p = 0; p < 8; p++) begin
			set_capacity(caps[p]);
			no_gap = (p % 3 == 0);
			repeat (40) send_random_cmd();
		end
		no_gap = 1'b0;
	endtask

	initial begin
		capacity_shadow = CAP_RESET;
		foreach (listed[i])
			listed[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_capacity_lowered();
		test_full_list();
		test_backpressure();
		test_random_mix();

		wait_results_done();
		repeat (8) @(posedge clk);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[lru_replacement_tracker_core.f]
rtl/core/lrt_pkg.sv
rtl/core/lrt_member.sv
rtl/core/lrt_list.sv
rtl/core/lru_replacement_tracker_core.sv
test/tb.sv
